// ===== src/tile_background_pixel_generator_assert.svh =====
// Assertion macros used by the checker of the tile background generator.
// Each expects signals named clk and arst_n in the scope where it is used.
`ifndef TILE_BACKGROUND_PIXEL_GENERATOR_ASSERT_SVH
`define TILE_BACKGROUND_PIXEL_GENERATOR_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define TBG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tile background check failed");

// The consequent must hold in the same cycle as the antecedent.
`define TBG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tile background check failed");

`endif

// ===== src/tbg_pkg.sv =====
// ----------------------------------------------------------------------------
// tbg_pkg
// Types and constants shared by the tile background pixel generator.
// ----------------------------------------------------------------------------
package tbg_pkg;

	localparam int TILE_BITS   = 4;
	localparam int TILE_SIZE   = 1 << TILE_BITS;
	localparam int SCREEN_ROWS = 240;
	localparam int FLIP_X_BIT  = 0;
	localparam int FLIP_Y_BIT  = 1;
	localparam int DIV_STEPS   = 32;

	localparam int DEF_MAP_ENTRIES    = 1024;
	localparam int DEF_SPRITE_COUNT   = 16;
	localparam int DEF_TILE_KINDS     = 8;
	localparam int DEF_PALETTE_COUNT  = 8;
	localparam int DEF_PALETTE_LENGTH = 8;

	typedef enum logic [2:0] {
		CMD_RENDER     = 3'd0,
		CMD_WR_MAP     = 3'd1,
		CMD_WR_PATTERN = 3'd2,
		CMD_WR_PALETTE = 3'd3,
		CMD_WR_KIND    = 3'd4,
		CMD_SET_TIME   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SCROLL_X    = 3'd0,
		REG_SCROLL_Y    = 3'd1,
		REG_MAP_WIDTH   = 3'd2,
		REG_MAP_HEIGHT  = 3'd3,
		REG_TRANSPARENT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_MAP,
		ST_RD_PAT,
		ST_RD_PAL,
		ST_DONE,
		ST_TM_CHECK,
		ST_TM_WAIT
	} state_t;

endpackage

// ===== src/tbg_divider.sv =====
// ----------------------------------------------------------------------------
// tbg_divider
// Restoring divider, one quotient bit per cycle, returning the low byte.
// ----------------------------------------------------------------------------
module tbg_divider import tbg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [7:0]  quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [7:0]  rem_q;
	logic [31:0] quo_q;
	logic [8:0]  shifted;
	logic        ge;

	assign shifted = {rem_q, quo_q[31]};
	assign ge      = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? 8'(shifted - {1'b0, divisor}) : shifted[7:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[7:0];

endmodule

// ===== src/tile_background_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// tile_background_pixel_generator
// Scrolling tile-map background: map, pattern and palette stores with a
// render pipeline that walks them one read at a time.
// ----------------------------------------------------------------------------
// A render request walks the states RD_MAP, RD_PAT, RD_PAL and DONE; DONE
// loads the result into the output register once that register is free, and
// the block then returns to idle to take the next item. The tile map, the
// pattern store and the palette store are read one after another, each
// through a synchronous read port. Store writes complete on acceptance and
// configuration writes are never back-pressured. A set-time transaction runs
// each kind's two scroll divisions through a shared bit-serial divider,
// skipping any delay of zero. Only one item is in work at a time; the output
// register lets the next item in while a result still waits.
module tile_background_pixel_generator import tbg_pkg::*; #(
	parameter int MAP_ENTRIES    = DEF_MAP_ENTRIES,
	parameter int SPRITE_COUNT   = DEF_SPRITE_COUNT,
	parameter int TILE_KINDS     = DEF_TILE_KINDS,
	parameter int PALETTE_COUNT  = DEF_PALETTE_COUNT,
	parameter int PALETTE_LENGTH = DEF_PALETTE_LENGTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// screen_x, screen_y, address, small_value, color_value, kind_sprite,
	// kind_palette, kind_flips, kind_delay_x, kind_delay_y, time_ms
	input  logic [119:0] s_axis_tdata,
	// command
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pixel_x, pixel_y, pixel_color
	output logic [47:0]  m_axis_tdata,
	// drawn
	output logic [0:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int PAT_ENTRIES = SPRITE_COUNT * TILE_SIZE * TILE_SIZE;
	localparam int PAL_ENTRIES = PALETTE_COUNT * PALETTE_LENGTH;
	localparam int MAP_AW      = $clog2(MAP_ENTRIES);
	localparam int PAT_AW      = $clog2(PAT_ENTRIES);
	localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
	localparam int KW          = $clog2(TILE_KINDS);

	// Input fields
	logic [2:0]  in_cmd;
	logic [7:0]  in_sx, in_sy;
	logic [11:0] in_addr;
	logic [2:0]  in_small;
	logic [31:0] in_color;
	logic [3:0]  in_sprite;
	logic [2:0]  in_pal;
	logic [1:0]  in_flips;
	logic [7:0]  in_dx, in_dy;
	logic [31:0] in_time;

	assign in_cmd    = s_axis_tuser;
	assign in_sx     = s_axis_tdata[7:0];
	assign in_sy     = s_axis_tdata[15:8];
	assign in_addr   = s_axis_tdata[27:16];
	assign in_small  = s_axis_tdata[30:28];
	assign in_color  = s_axis_tdata[62:31];
	assign in_sprite = s_axis_tdata[66:63];
	assign in_pal    = s_axis_tdata[69:67];
	assign in_flips  = s_axis_tdata[71:70];
	assign in_dx     = s_axis_tdata[79:72];
	assign in_dy     = s_axis_tdata[87:80];
	assign in_time   = s_axis_tdata[119:88];

	state_t state_q, state_d;
	logic   accept;
	logic   out_load;
	logic   div_start;

	// Configuration registers
	logic [9:0]  scroll_x_q, scroll_y_q;
	logic [6:0]  map_width_q, map_height_q;
	logic [31:0] transp_q;

	// Kind table and scroll offsets, in flops
	logic [3:0] kind_sprite_q [TILE_KINDS];
	logic [2:0] kind_pal_q    [TILE_KINDS];
	logic [1:0] kind_flips_q  [TILE_KINDS];
	logic [7:0] kind_dx_q     [TILE_KINDS];
	logic [7:0] kind_dy_q     [TILE_KINDS];
	logic [7:0] off_x_q       [TILE_KINDS];
	logic [7:0] off_y_q       [TILE_KINDS];

	// Memories
	logic [2:0]  map_mem [MAP_ENTRIES];
	logic [2:0]  pat_mem [PAT_ENTRIES];
	logic [31:0] pal_mem [PAL_ENTRIES];
	logic        pal_vld_q [PAL_ENTRIES];
	logic [2:0]  map_q;
	logic [2:0]  pat_q;
	logic [31:0] pal_q;
	logic        pal_rvld_q;

	// Pipeline registers
	logic [7:0]        sx_s1, sy_s1;
	logic [TILE_BITS-1:0] px_s1, py_s1;
	logic [MAP_AW-1:0] idx_s1;
	logic              ok_s1, ok_s2, ok_s3;
	logic [2:0]        pal_sel_s2;

	// Time sequencer
	logic [KW-1:0] div_k_q;
	logic          div_ax_q;
	logic [31:0]   time_q;
	logic          div_done;
	logic [7:0]    div_quo;
	logic [7:0]    cur_delay;
	logic          tm_last;

	// Output register
	logic        out_valid_q;
	logic [7:0]  out_x_q, out_y_q;
	logic [31:0] out_color_q;
	logic        out_drawn_q;

	assign accept = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------
	// Address and check for the first stage
	logic [10:0] wx, wy;
	logic [6:0]  tx, ty;
	logic [13:0] idx_full;
	logic        ok0;

	assign wx       = {1'b0, scroll_x_q} + 11'(in_sx);
	assign wy       = {1'b0, scroll_y_q} + 11'(in_sy);
	assign tx       = wx[10:TILE_BITS];
	assign ty       = wy[10:TILE_BITS];
	assign idx_full = 14'(ty) * 14'(map_width_q) + 14'(tx);
	assign ok0      = (in_sy < 8'(SCREEN_ROWS)) && (tx < map_width_q)
		&& (ty < map_height_q) && (32'(idx_full) < 32'(MAP_ENTRIES));

	// ------------------------------------------------------------------
	// Kind lookup, shared by the render path and the time sequencer
	logic                 code_ok;
	logic [KW-1:0]        kidx;
	logic [3:0]           k_sprite;
	logic [2:0]           k_pal;
	logic [1:0]           k_flips;
	logic [TILE_BITS-1:0] cx, cy;
	logic [PAT_AW-1:0]    pat_raddr;
	logic                 ok2;

	assign code_ok = (map_q != 3'd0) && (32'(map_q) < 32'(TILE_KINDS));

	always_comb begin
		if (state_q == ST_TM_CHECK || state_q == ST_TM_WAIT) begin
			kidx = div_k_q;
		end else if (code_ok) begin
			kidx = KW'(map_q);
		end else begin
			kidx = '0;
		end
	end

	assign k_sprite = kind_sprite_q[kidx];
	assign k_pal    = kind_pal_q[kidx];
	assign k_flips  = kind_flips_q[kidx];

	always_comb begin
		cx = px_s1 + off_x_q[kidx][TILE_BITS-1:0];
		cy = py_s1 - off_y_q[kidx][TILE_BITS-1:0];
		if (k_flips[FLIP_X_BIT]) begin
			cx = ~cx;
		end
		if (k_flips[FLIP_Y_BIT]) begin
			cy = ~cy;
		end
	end

	assign pat_raddr = PAT_AW'({k_sprite, cy, cx});
	assign ok2 = ok_s1 && code_ok && (32'(k_sprite) < 32'(SPRITE_COUNT))
		&& (32'(k_pal) < 32'(PALETTE_COUNT));

	// Palette address from the colour index
	logic [PAL_AW-1:0] pal_raddr;
	logic              ok3;

	assign pal_raddr = PAL_AW'(8'(pal_sel_s2) * 8'(PALETTE_LENGTH) + 8'(pat_q));
	assign ok3       = ok_s2 && (32'(pat_q) < 32'(PALETTE_LENGTH));

	// ------------------------------------------------------------------
	// Memories: write on an accepted store transaction, read every cycle
	logic map_we, pat_we, pal_we, kind_we;
	cmd_t cmd_e;

	assign cmd_e   = cmd_t'(in_cmd);
	assign map_we  = accept && cmd_e == CMD_WR_MAP && 32'(in_addr) < 32'(MAP_ENTRIES);
	assign pat_we  = accept && cmd_e == CMD_WR_PATTERN && 32'(in_addr) < 32'(PAT_ENTRIES);
	assign pal_we  = accept && cmd_e == CMD_WR_PALETTE && 32'(in_addr) < 32'(PAL_ENTRIES);
	assign kind_we = accept && cmd_e == CMD_WR_KIND && 32'(in_addr) < 32'(TILE_KINDS);

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[MAP_AW'(in_addr)] <= in_small;
		end
		map_q <= map_mem[idx_s1];
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[PAT_AW'(in_addr)] <= in_small;
		end
		pat_q <= pat_mem[pat_raddr];
	end

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[PAL_AW'(in_addr)] <= in_color;
		end
		pal_q <= pal_mem[pal_raddr];
	end

	// An entry that was never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAL_ENTRIES; i++) begin
				pal_vld_q[i] <= 1'b0;
			end
			pal_rvld_q <= 1'b0;
		end else begin
			if (pal_we) begin
				pal_vld_q[PAL_AW'(in_addr)] <= 1'b1;
			end
			pal_rvld_q <= pal_vld_q[pal_raddr];
		end
	end

	// ------------------------------------------------------------------
	// Configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_x_q   <= '0;
			scroll_y_q   <= '0;
			map_width_q  <= 7'd32;
			map_height_q <= 7'd15;
			transp_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SCROLL_X:    scroll_x_q   <= cfg_data[9:0];
				REG_SCROLL_Y:    scroll_y_q   <= cfg_data[9:0];
				REG_MAP_WIDTH:   map_width_q  <= cfg_data[6:0];
				REG_MAP_HEIGHT:  map_height_q <= cfg_data[6:0];
				REG_TRANSPARENT: transp_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Kind table and scroll offsets
	assign cur_delay = div_ax_q ? kind_dy_q[div_k_q] : kind_dx_q[div_k_q];
	assign tm_last   = div_ax_q && (div_k_q == KW'(TILE_KINDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TILE_KINDS; i++) begin
				kind_sprite_q[i] <= '0;
				kind_pal_q[i]    <= '0;
				kind_flips_q[i]  <= '0;
				kind_dx_q[i]     <= '0;
				kind_dy_q[i]     <= '0;
				off_x_q[i]       <= '0;
				off_y_q[i]       <= '0;
			end
		end else begin
			if (kind_we) begin
				kind_sprite_q[KW'(in_addr)] <= in_sprite;
				kind_pal_q[KW'(in_addr)]    <= in_pal;
				kind_flips_q[KW'(in_addr)]  <= in_flips;
				kind_dx_q[KW'(in_addr)]     <= in_dx;
				kind_dy_q[KW'(in_addr)]     <= in_dy;
			end
			if (state_q == ST_TM_WAIT && div_done) begin
				if (div_ax_q) begin
					off_y_q[div_k_q] <= div_quo;
				end else begin
					off_x_q[div_k_q] <= div_quo;
				end
			end
		end
	end

	// Walks kinds and axes in order during a set-time transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_k_q  <= '0;
			div_ax_q <= 1'b0;
		end else if (accept) begin
			div_k_q  <= '0;
			div_ax_q <= 1'b0;
		end else if ((state_q == ST_TM_CHECK && cur_delay == 8'd0)
			|| (state_q == ST_TM_WAIT && div_done)) begin
			div_ax_q <= ~div_ax_q;
			if (div_ax_q) begin
				div_k_q <= div_k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			time_q <= in_time;
		end
	end

	tbg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (time_q),
		.divisor  (cur_delay),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ------------------------------------------------------------------
	// Render pipeline registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sx_s1  <= in_sx;
			sy_s1  <= in_sy;
			px_s1  <= wx[TILE_BITS-1:0];
			py_s1  <= wy[TILE_BITS-1:0];
			idx_s1 <= MAP_AW'(idx_full);
			ok_s1  <= ok0;
		end
		if (state_q == ST_RD_PAT) begin
			ok_s2      <= ok2;
			pal_sel_s2 <= k_pal;
		end
		if (state_q == ST_RD_PAL) begin
			ok_s3 <= ok3;
		end
	end

	// ------------------------------------------------------------------
	// Control
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd_e == CMD_RENDER) begin
					state_d = ST_RD_MAP;
				end else if (accept && cmd_e == CMD_SET_TIME) begin
					state_d = ST_TM_CHECK;
				end
			end
			ST_RD_MAP: state_d = ST_RD_PAT;
			ST_RD_PAT: state_d = ST_RD_PAL;
			ST_RD_PAL: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			ST_TM_CHECK: begin
				if (cur_delay != 8'd0) begin
					state_d = ST_TM_WAIT;
				end else if (tm_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_TM_WAIT: begin
				if (div_done) begin
					state_d = tm_last ? ST_IDLE : ST_TM_CHECK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE:     s_axis_tready = 1'b1;
			ST_TM_CHECK: div_start = cur_delay != 8'd0;
			ST_DONE:     out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	logic [31:0] color_rd;
	logic        drawn_rd;

	assign color_rd = pal_rvld_q ? pal_q : 32'd0;
	assign drawn_rd = ok_s3 && (color_rd != transp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q     <= sx_s1;
			out_y_q     <= sy_s1;
			out_color_q <= drawn_rd ? color_rd : 32'd0;
			out_drawn_q <= drawn_rd;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_color_q, out_y_q, out_x_q};
	assign m_axis_tuser  = out_drawn_q;

endmodule

// ===== src/tbg_checker.sv =====
// ----------------------------------------------------------------------------
// tbg_checker
// Port-level checks for the tile background pixel generator.
// ----------------------------------------------------------------------------
`include "tile_background_pixel_generator_assert.svh"

module tbg_checker import tbg_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [119:0] s_axis_tdata,
	input logic [2:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [47:0]  m_axis_tdata,
	input logic [0:0]   m_axis_tuser,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [2:0]   cfg_index,
	input logic [31:0]  cfg_data
);

	// A stalled result keeps its payload.
	`TBG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// A render transaction occupies the block for the following cycle.
	`TBG_ASSERT_NEXT(a_render_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_RENDER, !s_axis_tready)

	// A pixel that is not drawn carries no colour.
	`TBG_ASSERT_NOW(a_undrawn_black, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[47:16] == 32'd0)

	// Configuration writes are never back-pressured.
	`TBG_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind tile_background_pixel_generator tbg_checker u_tbg_checker (.*);
